FILE: sv/bfnp_pkg.sv
// Shared types, constants and codes for the nearest-point search block.
package bfnp_pkg;

   // Field widths fixed by the request and response formats
   localparam int IDX_W         = 12;
   localparam int COORD_FIELD_W = 16;
   localparam int CNT_W         = 13;
   localparam int DIST_OUT_W    = 34;
   localparam int REQ_TDATA_W   = 64;
   localparam int RSP_TDATA_W   = 48;
   localparam int RSP_TUSER_W   = 2;

   // Request tdata layout
   localparam int REQ_IDX_LSB = 0;
   localparam int REQ_X_LSB   = REQ_IDX_LSB + IDX_W;
   localparam int REQ_Y_LSB   = REQ_X_LSB + COORD_FIELD_W;
   localparam int REQ_Z_LSB   = REQ_Y_LSB + COORD_FIELD_W;

   // Default sizing
   localparam int MAX_POINTS_DEF = 4096;
   localparam int LANES_DEF      = 8;
   localparam int COORD_BITS_DEF = 16;

   // Latencies of the datapath pieces, in cycles
   localparam int DIV_LAT  = 2;
   localparam int WR_LAT   = 2 * DIV_LAT;
   localparam int PIPE_LAT = 4;
   localparam int WAIT_W   = 3;

   typedef enum logic {
      OP_WRITE = 1'b0,
      OP_QUERY = 1'b1
   } op_type;

   typedef enum logic [1:0] {
      RSP_FOUND,
      RSP_EMPTY,
      RSP_ERROR
   } rsp_kind_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_WR_WAIT,
      ST_WR_COMMIT,
      ST_Q_WAIT,
      ST_Q_DECIDE,
      ST_SCAN,
      ST_DRAIN,
      ST_REDUCE,
      ST_RESULT
   } state_type;

   typedef struct packed {
      logic         capture;
      logic         wr_en;
      logic         scan_init;
      logic         issue;
      logic         red_step;
      logic         load_rsp;
      rsp_kind_type rsp_kind;
   } dp_cmd_type;

   typedef struct packed {
      logic count_err;
      logic count_zero;
      logic issue_last;
      logic red_last;
   } dp_status_type;

endpackage

FILE: sv/bfnp_cdiv.sv
// Two-stage divider by a constant: reciprocal multiply, then remainder.
module bfnp_cdiv
   import bfnp_pkg::*;
#(
   parameter int A_W     = IDX_W,
   parameter int DIVISOR = LANES_DEF
)
(
   input  logic           clock,
   input  logic [A_W-1:0] dividend,
   output logic [A_W-1:0] quot,
   output logic [A_W-1:0] rem
);

   localparam int L   = $clog2(DIVISOR);
   localparam int S   = A_W + L;
   localparam int M_W = A_W + 1;
   localparam int D_W = $clog2(DIVISOR + 1);
   localparam longint unsigned M_VAL =
      ((longint'(1) << S) + longint'(DIVISOR) - 1) / longint'(DIVISOR);
   localparam logic [M_W-1:0] M_CONST = M_W'(M_VAL);
   localparam logic [D_W-1:0] D_CONST = D_W'(DIVISOR);

   logic [A_W-1:0]     a_ff;
   logic [A_W-1:0]     q_ff;
   logic [A_W-1:0]     q_in;
   logic [A_W+M_W-1:0] prod;
   logic [A_W+D_W-1:0] qd;
   logic [A_W-1:0]     quot_ff;
   logic [A_W-1:0]     rem_ff;

   // exact floor for every A_W-bit dividend
   always_comb begin
      prod = dividend * M_CONST;
      q_in = A_W'(prod >> S);
      qd   = q_ff * D_CONST;
   end

   always_ff @(posedge clock) begin
      a_ff    <= dividend;
      q_ff    <= q_in;
      quot_ff <= q_ff;
      rem_ff  <= a_ff - qd[A_W-1:0];
   end

   assign quot = quot_ff;
   assign rem  = rem_ff;

endmodule

FILE: sv/bfnp_ctrl.sv
// Controller state machine: sequences writes, scans, reduction and response.
module bfnp_ctrl
   import bfnp_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_tvalid,
   input  logic          req_tuser,
   output logic          req_tready,
   output logic          rsp_tvalid,
   input  logic          rsp_tready,
   output dp_cmd_type    cmd,
   input  dp_status_type status
);

   state_type    state_ff, state_in;
   logic [WAIT_W-1:0] wait_ff, wait_in;
   rsp_kind_type kind_ff, kind_in;
   logic         rsp_valid_ff, rsp_valid_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         wait_ff      <= '0;
         kind_ff      <= RSP_EMPTY;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         wait_ff      <= wait_in;
         kind_ff      <= kind_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in     = state_ff;
      wait_in      = wait_ff + WAIT_W'(1);
      kind_in      = kind_ff;
      req_tready   = 1'b0;
      cmd          = '0;
      cmd.rsp_kind = kind_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;

      unique case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            wait_in    = '0;
            if (req_tvalid) begin
               cmd.capture = 1'b1;
               if (op_type'(req_tuser) == OP_QUERY) begin
                  state_in = ST_Q_WAIT;
               end else begin
                  state_in = ST_WR_WAIT;
               end
            end
         end
         ST_WR_WAIT: begin
            if (wait_ff == WAIT_W'(WR_LAT - 1)) begin
               state_in = ST_WR_COMMIT;
            end
         end
         ST_WR_COMMIT: begin
            cmd.wr_en = 1'b1;
            state_in  = ST_IDLE;
         end
         ST_Q_WAIT: begin
            if (wait_ff == WAIT_W'(DIV_LAT - 1)) begin
               state_in = ST_Q_DECIDE;
            end
         end
         ST_Q_DECIDE: begin
            wait_in = '0;
            priority if (status.count_err) begin
               kind_in  = RSP_ERROR;
               state_in = ST_RESULT;
            end else if (status.count_zero) begin
               kind_in  = RSP_EMPTY;
               state_in = ST_RESULT;
            end else begin
               cmd.scan_init = 1'b1;
               state_in      = ST_SCAN;
            end
         end
         ST_SCAN: begin
            cmd.issue = 1'b1;
            wait_in   = '0;
            if (status.issue_last) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            if (wait_ff == WAIT_W'(PIPE_LAT - 1)) begin
               state_in = ST_REDUCE;
            end
         end
         ST_REDUCE: begin
            cmd.red_step = 1'b1;
            if (status.red_last) begin
               kind_in  = RSP_FOUND;
               state_in = ST_RESULT;
            end
         end
         ST_RESULT: begin
            if (!rsp_valid_ff || rsp_tready) begin
               cmd.load_rsp = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign rsp_tvalid = rsp_valid_ff;

endmodule

FILE: sv/bfnp_dp.sv
// Datapath: point memories, lane distance pipelines, lane minima and reduction.
module bfnp_dp
   import bfnp_pkg::*;
#(
   parameter int MAX_POINTS = MAX_POINTS_DEF,
   parameter int LANES      = LANES_DEF,
   parameter int COORD_BITS = COORD_BITS_DEF
)
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_wr_en,
   input  logic [CNT_W-1:0]       csr_wr_data,
   input  logic [REQ_TDATA_W-1:0] req_tdata,
   input  dp_cmd_type             cmd,
   output dp_status_type          status,
   output logic [RSP_TDATA_W-1:0] rsp_tdata,
   output logic [RSP_TUSER_W-1:0] rsp_tuser
);

   localparam int CB      = COORD_BITS;
   localparam int RAW_W   = (CB > COORD_FIELD_W) ? CB : COORD_FIELD_W;
   localparam int ROWS    = (MAX_POINTS + LANES - 1) / LANES;
   localparam int ROW_W   = (ROWS > 1) ? $clog2(ROWS) : 1;
   localparam int LANE_W  = (LANES > 1) ? $clog2(LANES) : 1;
   localparam int SLOT_W  = $clog2(MAX_POINTS);
   localparam int NW0     = $clog2(MAX_POINTS + 1);
   localparam int NW      = (NW0 > CNT_W) ? NW0 : CNT_W;
   localparam int SQ_W    = 2 * CB + 1;
   localparam int DIST_W  = 2 * CB + 2;
   localparam int WORD_W  = 3 * CB;

   // ---------------- configuration and captured request ----------------
   logic [CNT_W-1:0]  count_ff;
   logic [IDX_W-1:0]  idx_ff;
   logic signed [CB-1:0] qx_ff, qy_ff, qz_ff;
   logic [RAW_W-1:0]  raw_x, raw_y, raw_z;

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else if (csr_wr_en) begin
         count_ff <= csr_wr_data;
      end
   end

   // fields are zero-extended, then the low CB bits are taken as signed
   always_comb begin
      raw_x = RAW_W'(req_tdata[REQ_X_LSB +: COORD_FIELD_W]);
      raw_y = RAW_W'(req_tdata[REQ_Y_LSB +: COORD_FIELD_W]);
      raw_z = RAW_W'(req_tdata[REQ_Z_LSB +: COORD_FIELD_W]);
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         idx_ff <= req_tdata[REQ_IDX_LSB +: IDX_W];
         qx_ff  <= raw_x[CB-1:0];
         qy_ff  <= raw_y[CB-1:0];
         qz_ff  <= raw_z[CB-1:0];
      end
   end

   // ---------------- slot, row and lane of a write; count check ----------------
   logic [IDX_W-1:0]  slot_q, slot_r;
   logic [SLOT_W-1:0] slot;
   logic [SLOT_W-1:0] row_q, lane_r;
   logic [CNT_W-1:0]  cnt_q, cnt_r;

   bfnp_cdiv #(.A_W(IDX_W), .DIVISOR(MAX_POINTS)) u_div_slot (
      .clock    (clock),
      .dividend (idx_ff),
      .quot     (slot_q),
      .rem      (slot_r)
   );

   assign slot = SLOT_W'(slot_r);

   bfnp_cdiv #(.A_W(SLOT_W), .DIVISOR(LANES)) u_div_row (
      .clock    (clock),
      .dividend (slot),
      .quot     (row_q),
      .rem      (lane_r)
   );

   bfnp_cdiv #(.A_W(CNT_W), .DIVISOR(LANES)) u_div_cnt (
      .clock    (clock),
      .dividend (count_ff),
      .quot     (cnt_q),
      .rem      (cnt_r)
   );

   logic [ROW_W-1:0]  wr_row;
   logic [LANE_W-1:0] wr_lane;

   assign wr_row  = ROW_W'(row_q);
   assign wr_lane = LANE_W'(lane_r);

   // ---------------- point memories, one per lane ----------------
   logic [WORD_W-1:0] mem [LANES][ROWS];
   logic [WORD_W-1:0] rd_ff [LANES];
   logic [ROW_W-1:0]  row_ff;

   always_ff @(posedge clock) begin
      for (int k = 0; k < LANES; k++) begin
         if (cmd.wr_en && wr_lane == LANE_W'(k)) begin
            mem[k][wr_row] <= {qz_ff, qy_ff, qx_ff};
         end
         rd_ff[k] <= mem[k][row_ff];
      end
   end

   // ---------------- scan issue ----------------
   logic [NW-1:0]    n_ff, n_in;
   logic [NW-1:0]    base_ff;
   logic [LANES-1:0] issue_mask;

   always_comb begin
      n_in = (NW'(count_ff) > NW'(MAX_POINTS)) ? NW'(MAX_POINTS) : NW'(count_ff);
      for (int k = 0; k < LANES; k++) begin
         issue_mask[k] = cmd.issue &&
            ((NW+1)'(base_ff) + (NW+1)'(k) < (NW+1)'(n_ff));
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.scan_init) begin
         n_ff    <= n_in;
         base_ff <= '0;
         row_ff  <= '0;
      end else if (cmd.issue) begin
         base_ff <= base_ff + NW'(LANES);
         row_ff  <= row_ff + ROW_W'(1);
      end
   end

   // ---------------- lane pipelines ----------------
   logic [LANES-1:0] mask_p1_ff, mask_p2_ff, mask_p3_ff, mask_p4_ff;
   logic [NW-1:0]    base_p1_ff, base_p2_ff, base_p3_ff, base_p4_ff;
   logic signed [CB:0] dx_ff [LANES];
   logic signed [CB:0] dy_ff [LANES];
   logic signed [CB:0] dz_ff [LANES];
   logic [SQ_W-1:0]  sx_ff [LANES];
   logic [SQ_W-1:0]  sy_ff [LANES];
   logic [SQ_W-1:0]  sz_ff [LANES];
   logic [DIST_W-1:0] sum_ff [LANES];

   always_ff @(posedge clock) begin
      if (reset) begin
         mask_p1_ff <= '0;
         mask_p2_ff <= '0;
         mask_p3_ff <= '0;
         mask_p4_ff <= '0;
      end else begin
         mask_p1_ff <= issue_mask;
         mask_p2_ff <= mask_p1_ff;
         mask_p3_ff <= mask_p2_ff;
         mask_p4_ff <= mask_p3_ff;
      end
   end

   always_ff @(posedge clock) begin
      base_p1_ff <= base_ff;
      base_p2_ff <= base_p1_ff;
      base_p3_ff <= base_p2_ff;
      base_p4_ff <= base_p3_ff;
   end

   logic signed [CB-1:0]    rx [LANES];
   logic signed [CB-1:0]    ry [LANES];
   logic signed [CB-1:0]    rz [LANES];
   logic signed [2*CB+1:0]  px [LANES];
   logic signed [2*CB+1:0]  py [LANES];
   logic signed [2*CB+1:0]  pz [LANES];

   always_comb begin
      for (int k = 0; k < LANES; k++) begin
         rx[k] = rd_ff[k][CB-1:0];
         ry[k] = rd_ff[k][2*CB-1:CB];
         rz[k] = rd_ff[k][3*CB-1:2*CB];
         px[k] = dx_ff[k] * dx_ff[k];
         py[k] = dy_ff[k] * dy_ff[k];
         pz[k] = dz_ff[k] * dz_ff[k];
      end
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k < LANES; k++) begin
         dx_ff[k]  <= {rx[k][CB-1], rx[k]} - {qx_ff[CB-1], qx_ff};
         dy_ff[k]  <= {ry[k][CB-1], ry[k]} - {qy_ff[CB-1], qy_ff};
         dz_ff[k]  <= {rz[k][CB-1], rz[k]} - {qz_ff[CB-1], qz_ff};
         sx_ff[k]  <= SQ_W'(px[k]);
         sy_ff[k]  <= SQ_W'(py[k]);
         sz_ff[k]  <= SQ_W'(pz[k]);
         sum_ff[k] <= DIST_W'(sx_ff[k]) + DIST_W'(sy_ff[k]) + DIST_W'(sz_ff[k]);
      end
   end

   // ---------------- per-lane minima (earliest strict minimum) ----------------
   logic [LANES-1:0]  lane_v_ff;
   logic [DIST_W-1:0] lane_d_ff [LANES];
   logic [SLOT_W-1:0] lane_i_ff [LANES];

   always_ff @(posedge clock) begin
      if (reset || cmd.scan_init) begin
         lane_v_ff <= '0;
      end else begin
         for (int k = 0; k < LANES; k++) begin
            if (mask_p4_ff[k] && (!lane_v_ff[k] || sum_ff[k] < lane_d_ff[k])) begin
               lane_v_ff[k] <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k < LANES; k++) begin
         if (mask_p4_ff[k] && (!lane_v_ff[k] || sum_ff[k] < lane_d_ff[k])) begin
            lane_d_ff[k] <= sum_ff[k];
            lane_i_ff[k] <= SLOT_W'(base_p4_ff + NW'(k));
         end
      end
   end

   // ---------------- final pick: lowest lane with the overall minimum ----------------
   logic [LANE_W-1:0] red_k_ff;
   logic              best_v_ff;
   logic [DIST_W-1:0] best_d_ff;
   logic [SLOT_W-1:0] best_i_ff;
   logic              take;

   assign take = lane_v_ff[red_k_ff] && (!best_v_ff || lane_d_ff[red_k_ff] < best_d_ff);

   always_ff @(posedge clock) begin
      if (reset || cmd.scan_init) begin
         red_k_ff  <= '0;
         best_v_ff <= 1'b0;
      end else if (cmd.red_step) begin
         red_k_ff <= red_k_ff + LANE_W'(1);
         if (take) begin
            best_v_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.red_step && take) begin
         best_d_ff <= lane_d_ff[red_k_ff];
         best_i_ff <= lane_i_ff[red_k_ff];
      end
   end

   // ---------------- status and response register ----------------
   always_comb begin
      status.count_err  = (cnt_r != '0);
      status.count_zero = (count_ff == '0);
      status.issue_last = ((NW+1)'(base_ff) + (NW+1)'(LANES) >= (NW+1)'(n_ff));
      status.red_last   = (red_k_ff == LANE_W'(LANES - 1));
   end

   logic [IDX_W-1:0]      rsp_idx_ff;
   logic [DIST_OUT_W-1:0] rsp_dist_ff;
   logic                  rsp_found_ff;
   logic                  rsp_err_ff;

   always_ff @(posedge clock) begin
      if (cmd.load_rsp) begin
         unique case (cmd.rsp_kind)
            RSP_FOUND: begin
               rsp_idx_ff   <= IDX_W'(best_i_ff);
               rsp_dist_ff  <= DIST_OUT_W'(best_d_ff);
               rsp_found_ff <= 1'b1;
               rsp_err_ff   <= 1'b0;
            end
            RSP_ERROR: begin
               rsp_idx_ff   <= '0;
               rsp_dist_ff  <= '0;
               rsp_found_ff <= 1'b0;
               rsp_err_ff   <= 1'b1;
            end
            default: begin
               rsp_idx_ff   <= '0;
               rsp_dist_ff  <= '0;
               rsp_found_ff <= 1'b0;
               rsp_err_ff   <= 1'b0;
            end
         endcase
      end
   end

   assign rsp_tdata = RSP_TDATA_W'({rsp_dist_ff, rsp_idx_ff});
   assign rsp_tuser = {rsp_err_ff, rsp_found_ff};

endmodule

FILE: sv/brute_force_nearest_point.sv
// Top level of the brute-force 3D nearest-point search block.
//
// Usage
//   req channel : one request per handshake. req_tuser is the opcode
//                 (0 = store a point at point_index, 1 = nearest query).
//   rsp channel : one response per query, none per store.
//   csr port    : csr_wr_en/csr_wr_data load point_count; write only while idle.
// Sequence
//   store : slot and lane found by two chained constant dividers, then the
//           memory commit; the next accept comes in the cycle after the commit.
//   query : point_count check, then a scan of ceil(n/LANES) memory rows
//           (one memory row of LANES points per cycle), a drain of the
//           distance pipeline, a reduction over the LANES lane minima and
//           the response load, which waits while an earlier response is
//           stalled. The memory read port sets the scan rate.
//   bad count or empty cloud: response loaded after the count check, no scan.
// One request is worked on at a time; req_tready is high only while idle.
// Reset clears point_count, the controller and the response valid; point
// memories are not cleared. A stalled response holds in its output register
// while the next request is already accepted; a later query waits for it.
module brute_force_nearest_point
   import bfnp_pkg::*;
#(
   parameter int MAX_POINTS = MAX_POINTS_DEF,
   parameter int LANES      = LANES_DEF,
   parameter int COORD_BITS = COORD_BITS_DEF
)
(
   input  logic                   clock,
   input  logic                   reset,
   // request: tdata = point_index[11:0], coord_x[27:12], coord_y[43:28],
   //          coord_z[59:44], zero pad [63:60]; tuser = opcode
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [REQ_TDATA_W-1:0] req_tdata,
   input  logic                   req_tuser,
   // response: tdata = nearest_index[11:0], distance_sq[45:12], pad [47:46]
   //           tuser = found[0], count_error[1]
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [RSP_TDATA_W-1:0] rsp_tdata,
   output logic [RSP_TUSER_W-1:0] rsp_tuser,
   // point_count register
   input  logic                   csr_wr_en,
   input  logic [CNT_W-1:0]       csr_wr_data
);

   dp_cmd_type    cmd;
   dp_status_type status;

   // sequencing only; all data stays in the datapath
   bfnp_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tuser  (req_tuser),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .cmd        (cmd),
      .status     (status)
   );

   bfnp_dp #(
      .MAX_POINTS (MAX_POINTS),
      .LANES      (LANES),
      .COORD_BITS (COORD_BITS)
   ) u_dp (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_tdata   (req_tdata),
      .cmd         (cmd),
      .status      (status),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser)
   );

endmodule

FILE: sv/bfnp_checker.sv
// Port-level checker for the nearest-point search block, with its bind.
module bfnp_checker
   import bfnp_pkg::*;
(
   input logic                   clock,
   input logic                   reset,
   input logic                   req_tvalid,
   input logic                   req_tready,
   input logic                   rsp_tvalid,
   input logic                   rsp_tready,
   input logic [RSP_TDATA_W-1:0] rsp_tdata,
   input logic [RSP_TUSER_W-1:0] rsp_tuser
);

   // one request at a time: ready drops right after an accept
   a_req_one: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("request ready held after accept");

   // a stalled response keeps its payload
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("response changed while stalled");

   // found and count_error never come together
   a_flags: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !(rsp_tuser[0] && rsp_tuser[1]))
      else $error("found and count_error both set");

   // no point found means index and distance read zero
   a_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser[0] |-> rsp_tdata == '0)
      else $error("nonzero payload without a found point");

   // reset drops any pending response
   a_reset: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("response valid after reset");

endmodule

bind brute_force_nearest_point bfnp_checker u_bfnp_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);
